>>> rtl/core/sli_pkg.sv
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int KeyW = 32;
	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int WideW = (CntW > 5) ? CntW : 5;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// request broadcast to every cell
	typedef struct packed {
		logic              apply;
		action_t           action;
		logic [KeyW-1:0]   key;
	} cell_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic              valid;
		logic              stay;
		logic              seen;
		logic [KeyW-1:0]   key;
	} cell_link_t;

endpackage

>>> rtl/core/sli_cell.sv
module sli_cell
	import sli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	logic [KeyW-1:0] key_q;
	logic            valid_q;
	logic            match;
	logic            less;
	logic            seen;
	logic            stay;

	assign match  = valid_q && (key_q == cmd.key);
	assign less   = $signed(key_q) < $signed(cmd.key);
	assign seen   = left.seen | match;
	assign stay   = (cmd.action == ACT_INSERT) ? (valid_q & less) : (valid_q & ~seen);

	assign link.valid  = valid_q;
	assign link.stay   = stay;
	assign link.seen   = seen;
	assign link.key    = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.apply && !stay) begin
			unique case (cmd.action)
				ACT_INSERT: valid_q <= left.stay ? 1'b1 : left.valid;
				ACT_DELETE: valid_q <= right.valid;
				default:    valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && !stay) begin
			unique case (cmd.action)
				ACT_INSERT: key_q <= left.stay ? cmd.key : left.key;
				ACT_DELETE: key_q <= right.key;
				default:    key_q <= key_q;
			endcase
		end
	end

endmodule

>>> rtl/core/sorted_list_insert_delete.sv
// The result strobe done is registered and rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, the cell row settles
// insert or delete position and shift in the same cycle as the request.
// Reset: arst_n clears the list to empty and drops done; stored keys are
// not cleared. The receiver cannot stall results.
module sorted_list_insert_delete
	import sli_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [31:0] key,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  position,
	output logic [4:0]  count
);

	localparam cell_link_t LeftEnd  = '{valid: 1'b1, stay: 1'b1, seen: 1'b0, key: '0};
	localparam cell_link_t RightEnd = '{valid: 1'b0, stay: 1'b0, seen: 1'b0, key: '0};

	cell_link_t          links [CAPACITY];
	cell_cmd_t           cmd;
	logic [CntW-1:0]     used_q;
	logic [CntW-1:0]     used_nxt;
	logic [CntW-1:0]     pos_cnt;
	logic [CntW-1:0]     pos_nxt;
	logic [CntW-1:0]     pos_q;
	logic [CntW-1:0]     cnt_q;
	status_t             status_nxt;
	status_t             status_q;
	logic                done_q;
	logic                accept;
	logic                full;
	logic                empty;
	logic                found;
	logic [WideW-1:0]    pos_wide;
	logic [WideW-1:0]    cnt_wide;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign full   = used_q == CntW'(CAPACITY);
	assign empty  = used_q == '0;
	assign found  = links[CAPACITY-1].seen;

	always_comb begin
		cmd.action = action_t'(action);
		cmd.key    = key;
		cmd.apply  = accept && ((action_t'(action) == ACT_INSERT) ? !full : found);
	end

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			cell_link_t lft;
			cell_link_t rgt;
			if (i == 0) begin : g_first
				assign lft = LeftEnd;
			end else begin : g_mid
				assign lft = links[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign rgt = RightEnd;
			end else begin : g_inner
				assign rgt = links[i+1];
			end
			sli_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.left   (lft),
				.right  (rgt),
				.link   (links[i])
			);
		end
	endgenerate

	always_comb begin
		pos_cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pos_cnt = pos_cnt + CntW'(links[i].stay);
		end
	end

	always_comb begin
		status_nxt = ST_INSERTED;
		pos_nxt    = '0;
		used_nxt   = used_q;
		priority if (action_t'(action) == ACT_INSERT && full) begin
			status_nxt = ST_FULL;
		end else if (action_t'(action) == ACT_INSERT) begin
			status_nxt = ST_INSERTED;
			pos_nxt    = pos_cnt;
			used_nxt   = used_q + CntW'(1);
		end else if (empty) begin
			status_nxt = ST_EMPTY;
		end else if (!found) begin
			status_nxt = ST_NOT_FOUND;
		end else begin
			status_nxt = ST_DELETED;
			pos_nxt    = pos_cnt;
			used_nxt   = used_q - CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				used_q <= used_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			pos_q    <= pos_nxt;
			cnt_q    <= used_nxt;
		end
	end

	assign pos_wide = WideW'(pos_q);
	assign cnt_wide = WideW'(cnt_q);
	assign done     = done_q;
	assign status   = status_q;
	assign position = pos_wide[3:0];
	assign count    = cnt_wide[4:0];

endmodule

>>> rtl/core/sli_checker.sv
module sli_checker
	import sli_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [3:0]  position,
	input logic [4:0]  count
);

	localparam logic [WideW-1:0] CapWide = WideW'(CAPACITY);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without request");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_NOT_FOUND || status == ST_EMPTY || status == ST_FULL))
		|-> position == 4'd0)
		else $error("nonzero position on failed request");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> count == CapWide[4:0])
		else $error("full without capacity count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> count == 5'd0)
		else $error("empty with nonzero count");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.position (position),
	.count    (count)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sli_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 310;
	localparam int POOL_N = 12;

	typedef struct packed {
		status_t     st;
		logic [3:0]  pos;
		logic [4:0]  cnt;
	} outcome_t;

	typedef struct packed {
		action_t     act;
		logic [31:0] k;
		logic        typed;
		outcome_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = 1'b0;
	logic [31:0] key = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [3:0]  position;
	logic [4:0]  count;

	// typed expectation travels with the request
	logic        req_typed = 1'b0;
	outcome_t    req_want = '0;

	logic [31:0] shadow_keys [CAPACITY];
	int          shadow_fill = 0;
	outcome_t    outcome_q [$];
	int          fault_count = 0;
	int          stall_cycles = 0;
	logic [31:0] key_pool [POOL_N];

	row_t dir_rows [24] = '{
		'{ACT_DELETE, 32'h0000_0000, 1'b1, '{ST_EMPTY,    4'd0, 5'd0}},
		'{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_INSERTED, 4'd0, 5'd1}},
		'{ACT_INSERT, 32'h8000_0000, 1'b1, '{ST_INSERTED, 4'd0, 5'd2}},
		'{ACT_INSERT, 32'h0000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_0000, 1'b0, '0},
		'{ACT_DELETE, 32'h0001_2345, 1'b0, '0},
		'{ACT_DELETE, 32'h0000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{ACT_INSERT, 32'h0001_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
		'{ACT_INSERT, 32'h8000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_8000, 1'b0, '0},
		'{ACT_INSERT, 32'hFFFF_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h5555_5555, 1'b0, '0},
		'{ACT_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_0001, 1'b0, '0},
		'{ACT_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
		'{ACT_INSERT, 32'h8000_0001, 1'b0, '0},
		'{ACT_INSERT, 32'h1234_5678, 1'b0, '0},
		'{ACT_INSERT, 32'hEDCB_A987, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_0000, 1'b1, '{ST_FULL,     4'd0, 5'd16}},
		'{ACT_DELETE, 32'h7FFF_FFFF, 1'b0, '0},
		'{ACT_DELETE, 32'h8000_0000, 1'b0, '0},
		'{ACT_DELETE, 32'h0000_0003, 1'b0, '0}
	};

	sorted_list_insert_delete DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.key      (key),
		.done     (done),
		.status   (status),
		.position (position),
		.count    (count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic sorted_store_update(input action_t act, input logic [31:0] k,
			output outcome_t res);
		int p;
		int i;
		p = 0;
		if (act == ACT_INSERT) begin
			if (shadow_fill >= CAPACITY) begin
				res = '{ST_FULL, 4'd0, 5'(shadow_fill)};
			end else begin
				while (p < shadow_fill && $signed(shadow_keys[p]) < $signed(k))
					p++;
				for (i = shadow_fill; i > p; i--)
					shadow_keys[i] = shadow_keys[i - 1];
				shadow_keys[p] = k;
				shadow_fill++;
				res = '{ST_INSERTED, 4'(p), 5'(shadow_fill)};
			end
		end else if (shadow_fill == 0) begin
			res = '{ST_EMPTY, 4'd0, 5'd0};
		end else begin
			while (p < shadow_fill && shadow_keys[p] != k)
				p++;
			if (p >= shadow_fill) begin
				res = '{ST_NOT_FOUND, 4'd0, 5'(shadow_fill)};
			end else begin
				for (i = p; i + 1 < shadow_fill; i++)
					shadow_keys[i] = shadow_keys[i + 1];
				shadow_fill--;
				res = '{ST_DELETED, 4'(p), 5'(shadow_fill)};
			end
		end
	endtask

	task automatic log_fault(input string what, input outcome_t want, input outcome_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t bad result (%s): want st=%0d pos=%0d cnt=%0d, got st=%0d pos=%0d cnt=%0d",
				$time, what, want.st, want.pos, want.cnt, got.st, got.pos, got.cnt);
	endtask

	// results, request capture and watchdog
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			if (done) begin
				got = '{status_t'(status), position, count};
				if (outcome_q.size() == 0) begin
					log_fault("unexpected", '0, got);
				end else begin
					want = outcome_q.pop_front();
					if (got.st !== want.st || got.pos !== want.pos || got.cnt !== want.cnt)
						log_fault("field", want, got);
				end
			end
			if (start && !busy) begin
				sorted_store_update(action_t'(action), key, want);
				outcome_q.push_back(req_typed ? req_want : want);
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic issue(input action_t a, input logic [31:0] k, input logic typed,
			input outcome_t w);
		action <= a;
		key <= k;
		req_typed <= typed;
		req_want <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_requests();
		start <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic refresh_pool();
		logic [31:0] r;
		key_pool[0] = 32'h7FFF_FFFF;
		key_pool[1] = 32'h8000_0000;
		for (int i = 2; i < POOL_N; i++) begin
			r = $urandom();
			if (i % 2)
				r = {{16{r[15]}}, r[15:0]};
			key_pool[i] = r;
		end
	endtask

	initial begin
		int idle_pct [3] = '{14, 81, 0};
		int run_left;
		bit grow;
		action_t act;
		logic [31:0] k;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			issue(dir_rows[i].act, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].want);
			sender_gap(idle_pct[0]);
		end
		drain_requests();

		run_left = 0;
		grow = 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			refresh_pool();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// alternate fill and drain tides so full and empty recur
				if (run_left == 0) begin
					grow = !grow;
					run_left = $urandom_range(12, 40);
				end
				run_left--;
				if (($urandom_range(0, 99) < 85) == grow)
					act = ACT_INSERT;
				else
					act = ACT_DELETE;
				if ($urandom_range(0, 99) < 15)
					k = $urandom();
				else
					k = key_pool[$urandom_range(0, POOL_N - 1)];
				issue(act, k, 1'b0, '0);
				sender_gap(idle_pct[ph]);
			end
			drain_requests();
		end

		repeat (4) @(posedge clk);
		if (fault_count == 0 && outcome_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
